// File: rtl/core/rdm_pkg.sv
// Shared types and constants of the dot-star regular expression matcher.
package rdm_pkg;

   // Widths of the transaction fields and of the configuration port.
   localparam int TEXT_W       = 8;
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_INDEX_W  = 3;
   localparam int MASK_W       = 16;
   localparam int LENGTH_W     = 5;

   // Number of elements that have stored literal, repeat and wildcard bits.
   localparam int STORED_ELEMS = 16;
   localparam int ELEMS_PER_WORD = CSR_DATA_W / TEXT_W;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTES_LOW  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTES_HIGH = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPEAT     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WILDCARD   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LENGTH     = 3'd4;

   // Decoded pattern element as seen by one cell.
   typedef struct packed {
      logic [TEXT_W-1:0] literal;
      logic              star;
      logic              wild;
      logic              enabled;
   } elem_type;

   // Signals handed from one cell to the next.
   typedef struct packed {
      logic carry;
      logic adv;
      logic fcarry;
   } link_type;

   // Per-transaction step control broadcast to every cell.
   typedef struct packed {
      logic              accept;
      logic              last;
      logic              present;
      logic [TEXT_W-1:0] text_byte;
   } step_type;

endpackage

// File: rtl/core/rdm_req_if.sv
// Request channel interface carrying the text bytes.
interface rdm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       byte_present;
   logic       end_of_text;

   modport source (output valid, output text_byte, output byte_present,
                   output end_of_text, input ready);
   modport sink (input valid, input text_byte, input byte_present,
                 input end_of_text, output ready);
endinterface

// File: rtl/core/rdm_rsp_if.sv
// Response channel interface carrying the match result.
interface rdm_rsp_if;
   logic valid;
   logic ready;
   logic matched;

   modport source (output valid, output matched, input ready);
   modport sink (input valid, input matched, output ready);
endinterface

// File: rtl/core/rdm_csr.sv
// Configuration registers and per-element pattern decode.
module rdm_csr #(
   parameter int PATTERN_LEN = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [rdm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rdm_pkg::CSR_DATA_W-1:0]     csr_data,
   output rdm_pkg::elem_type [PATTERN_LEN:0]  elems,
   output logic [$clog2(PATTERN_LEN+1)-1:0]   eff_len
);
   import rdm_pkg::*;

   localparam int LEN_W = $clog2(PATTERN_LEN + 1);

   logic [CSR_DATA_W-1:0] bytes_low_ff, bytes_low_in;
   logic [CSR_DATA_W-1:0] bytes_high_ff, bytes_high_in;
   logic [MASK_W-1:0]     repeat_ff, repeat_in;
   logic [MASK_W-1:0]     wildcard_ff, wildcard_in;
   logic [LENGTH_W-1:0]   length_ff, length_in;

   // Register writes by index; unknown indexes are ignored.
   always_comb begin
      bytes_low_in  = bytes_low_ff;
      bytes_high_in = bytes_high_ff;
      repeat_in     = repeat_ff;
      wildcard_in   = wildcard_ff;
      length_in     = length_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_BYTES_LOW:  bytes_low_in  = csr_data;
            CSR_BYTES_HIGH: bytes_high_in = csr_data;
            CSR_REPEAT:     repeat_in     = csr_data[MASK_W-1:0];
            CSR_WILDCARD:   wildcard_in   = csr_data[MASK_W-1:0];
            CSR_LENGTH:     length_in     = csr_data[LENGTH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_low_ff  <= '0;
         bytes_high_ff <= '0;
         repeat_ff     <= '0;
         wildcard_ff   <= '0;
         length_ff     <= '0;
      end else begin
         bytes_low_ff  <= bytes_low_in;
         bytes_high_ff <= bytes_high_in;
         repeat_ff     <= repeat_in;
         wildcard_ff   <= wildcard_in;
         length_ff     <= length_in;
      end
   end

   // A length beyond PATTERN_LEN saturates to PATTERN_LEN.
   always_comb begin
      if (32'(length_ff) > PATTERN_LEN) begin
         eff_len = LEN_W'(PATTERN_LEN);
      end else begin
         eff_len = LEN_W'(length_ff);
      end
   end

   // Element decode; elements without storage are unstarred literal zero bytes.
   // The slot past the last element is the final position and never matches.
   for (genvar i = 0; i <= PATTERN_LEN; i++) begin : g_elem
      if (i < ELEMS_PER_WORD) begin : g_low
         assign elems[i].literal = bytes_low_ff[i*TEXT_W +: TEXT_W];
      end else if (i < STORED_ELEMS) begin : g_high
         assign elems[i].literal = bytes_high_ff[(i-ELEMS_PER_WORD)*TEXT_W +: TEXT_W];
      end else begin : g_none
         assign elems[i].literal = '0;
      end
      if (i < STORED_ELEMS) begin : g_masks
         assign elems[i].star = repeat_ff[i];
         assign elems[i].wild = wildcard_ff[i];
      end else begin : g_nomasks
         assign elems[i].star = 1'b0;
         assign elems[i].wild = 1'b0;
      end
      assign elems[i].enabled = (32'(eff_len) > i);
   end

endmodule

// File: rtl/core/rdm_cell.sv
// One position cell of the matcher chain: active bit, closure and advance.
module rdm_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              home,
   input  rdm_pkg::elem_type elem,
   input  rdm_pkg::step_type step,
   input  rdm_pkg::link_type link_in,
   output rdm_pkg::link_type link_out,
   output logic              final_bit
);
   import rdm_pkg::*;

   logic state_ff, state_in;
   logic hold_ff, hold_in;
   logic cur;
   logic hit;
   logic nxt;
   logic after;
   logic fcur;

   // Close the current position over a skippable starred element upstream.
   assign cur = state_ff | link_in.carry;
   assign hit = elem.enabled & cur & (elem.wild | (elem.literal == step.text_byte));

   // A starred element stays in place on a hit, a plain one advances.
   assign link_out.carry = cur & elem.star & elem.enabled;
   assign link_out.adv   = hit & ~elem.star;
   assign nxt            = (hit & elem.star) | link_in.adv;
   assign after          = step.present ? nxt : state_ff;

   // State update; the last transaction of a text restores the start set.
   always_comb begin
      state_in = state_ff;
      hold_in  = hold_ff;
      if (step.accept) begin
         if (step.last) begin
            state_in = home;
            hold_in  = after;
         end else begin
            state_in = after;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= home;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

   // Closure of the held end-of-text set, used for the result.
   assign fcur            = hold_ff | link_in.fcarry;
   assign link_out.fcarry = fcur & elem.star & elem.enabled;
   assign final_bit       = fcur;

endmodule

// File: rtl/core/regex_dot_star_matcher_core.sv
// Top level of the streaming dot-star regular expression matcher.
//
// Usage: program the pattern through the csr_ write port while the block is
// idle (literal bytes of elements 0-7 and 8-15, repeat mask, wildcard mask,
// length). Then stream text on req_bus, one byte per transaction; set
// end_of_text on the last transaction of each text. A transaction without a
// byte (byte_present low) leaves the state alone, and with end_of_text it
// tests the empty text or the bytes seen so far.
// Each text yields one transaction on rsp_bus with matched set when the
// whole text matches the whole pattern.
// Throughput is one transaction per cycle while req_bus.ready is high, set
// by the row of position cells that advances the whole active set on each
// accepted transaction. The accepting edge of the last byte updates the set
// into the hold registers; the output register, which drives rsp_bus, takes its closure when free.
// When rsp_bus stalls, one more finished text is held inside; after that
// req_bus.ready drops until the response is taken.
// Reset (synchronous) clears the configuration and leaves only the start
// position active, so a new text may follow at once.
module regex_dot_star_matcher_core #(
   parameter int PATTERN_LEN = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   rdm_req_if.sink                         req_bus,
   rdm_rsp_if.source                       rsp_bus,
   input  logic                            csr_write_en,
   input  logic [rdm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rdm_pkg::CSR_DATA_W-1:0]  csr_data
);
   import rdm_pkg::*;

   localparam int LEN_W = $clog2(PATTERN_LEN + 1);

   elem_type [PATTERN_LEN:0] elems;
   logic [LEN_W-1:0]         eff_len;
   link_type                 links [PATTERN_LEN+1:0];
   logic [PATTERN_LEN:0]     final_bits;
   step_type                 step;

   logic pending_ff, pending_in;
   logic out_valid_ff, out_valid_in;
   logic out_matched_ff, out_matched_in;
   logic out_load;
   logic accept;

   rdm_csr #(
      .PATTERN_LEN (PATTERN_LEN)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .elems        (elems),
      .eff_len      (eff_len)
   );

   // Handshake: the held result moves out whenever the output register frees.
   assign out_load      = ~out_valid_ff | rsp_bus.ready;
   assign req_bus.ready = ~pending_ff | out_load;
   assign accept        = req_bus.valid & req_bus.ready;

   assign step.accept    = accept;
   assign step.last      = req_bus.end_of_text;
   assign step.present   = req_bus.byte_present;
   assign step.text_byte = req_bus.text_byte;

   // Row of position cells; the last one is the position past the pattern.
   assign links[0] = '0;
   for (genvar i = 0; i <= PATTERN_LEN; i++) begin : g_cell
      rdm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .home      (i == 0),
         .elem      (elems[i]),
         .step      (step),
         .link_in   (links[i]),
         .link_out  (links[i+1]),
         .final_bit (final_bits[i])
      );
   end

   // Pending end-of-text set and output register.
   always_comb begin
      pending_in     = pending_ff;
      out_valid_in   = out_valid_ff;
      out_matched_in = out_matched_ff;
      if (out_load) begin
         out_valid_in   = pending_ff;
         out_matched_in = final_bits[eff_len];
         pending_in     = 1'b0;
      end
      if (accept && req_bus.end_of_text) begin
         pending_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_matched_ff <= out_matched_in;
   end

   assign rsp_bus.valid   = out_valid_ff;
   assign rsp_bus.matched = out_matched_ff;

endmodule
